>>> src/discrete_cdf_sampler_defines.svh
// Assertion macros for the discrete CDF sampler checker.
// Needs a clk_i and an active-low rst_ni in the scope where a macro is used.
`ifndef DISCRETE_CDF_SAMPLER_DEFINES_SVH
`define DISCRETE_CDF_SAMPLER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define DCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dcs_pkg.sv
// Shared types and constants of the discrete CDF sampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcs_pkg;

  localparam int DefDepth      = 1024;
  localparam int DefWeightBits = 16;
  localparam int DefFracBits   = 24;
  localparam int IndexBits     = 10;  // width of the index result field
  localparam int QueueDepth    = 2;   // words between front and back

  // Command class decided by the front end.
  typedef enum logic [1:0] {
    OpLoad,
    OpLoadFirst,
    OpQuery
  } op_e;

  localparam int OpBits = $bits(op_e);

endpackage

`default_nettype wire

>>> src/dcs_front.sv
// Front end: accepts command words and classifies them into queue words.
// Depends on dcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcs_front import dcs_pkg::*; #(
  parameter int WeightBits = DefWeightBits,
  parameter int FracBits   = DefFracBits,
  localparam int DataBits  = (WeightBits > FracBits) ? WeightBits : FracBits,
  localparam int WordBits  = DataBits + OpBits
) (
  input  wire logic                  start_i,
  input  wire logic                  req_type_i,
  input  wire logic                  first_entry_i,
  input  wire logic [WeightBits-1:0] weight_i,
  input  wire logic [FracBits-1:0]   r_fraction_i,
  input  wire logic                  full_i,
  output logic                       busy_o,
  output logic                       push_o,
  output logic [WordBits-1:0]        word_o
);

  op_e                 op;
  logic [DataBits-1:0] data;

  // Loads carry the weight, queries the fraction; the other field is dropped.
  always_comb begin
    if (req_type_i) begin
      op   = OpQuery;
      data = DataBits'(r_fraction_i);
    end else begin
      op   = first_entry_i ? OpLoadFirst : OpLoad;
      data = DataBits'(weight_i);
    end
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;
  assign word_o = {op, data};

endmodule

`default_nettype wire

>>> src/dcs_fifo.sv
// Short register queue between the front and back ends.
// Depends on dcs_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module dcs_fifo import dcs_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth,
  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntBits = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [Width-1:0]      data_o,
  input  wire logic             pop_i
);

  logic [Width-1:0]   slot_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == CntBits'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> src/dcs_back.sv
// Back end: prefix-sum table, load execution and binary-search sampler.
// Depends on dcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcs_back import dcs_pkg::*; #(
  parameter int Depth      = DefDepth,
  parameter int WeightBits = DefWeightBits,
  parameter int FracBits   = DefFracBits,
  localparam int DataBits  = (WeightBits > FracBits) ? WeightBits : FracBits,
  localparam int WordBits  = DataBits + OpBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire logic [WordBits-1:0] head_word_i,
  output logic                     pop_o,
  output logic                     result_valid_o,
  output logic [IndexBits-1:0]     index_o,
  output logic                     overflow_seen_o
);

  localparam int IdxBits   = $clog2(Depth);
  localparam int CountBits = $clog2(Depth + 1);
  localparam int SumBits   = WeightBits + IdxBits;
  localparam int CmpBits   = SumBits + FracBits;
  localparam int LoBits    = SumBits / 2;
  localparam int HiBits    = SumBits - LoBits;

  typedef enum logic [1:0] {
    StIdle,
    StMulLo,
    StMulHi,
    StSearch
  } state_e;

  state_e               state_q;
  logic [CountBits-1:0] count_q;
  logic [SumBits-1:0]   total_q;
  logic                 ovf_q;
  logic [FracBits-1:0]  r_q;
  logic [IdxBits-1:0]   lo_q, hi_q, mid_q;
  logic [CmpBits-1:0]   prod_q;
  logic                 res_valid_q;
  logic [IndexBits-1:0] index_q;
  logic                 res_ovf_q;

  logic [SumBits-1:0]   prefix_mem [Depth];
  logic [SumBits-1:0]   rd_data_q;

  // Head decode
  op_e                  head_op;
  logic [DataBits-1:0]  head_data;
  logic                 is_load, is_query;

  assign head_op   = op_e'(head_word_i[WordBits-1 -: OpBits]);
  assign head_data = head_word_i[DataBits-1:0];

  always_comb begin
    is_load  = 1'b0;
    is_query = 1'b0;
    unique case (head_op)
      OpLoad, OpLoadFirst: is_load  = 1'b1;
      OpQuery:             is_query = 1'b1;
      default:             ;
    endcase
  end

  // Load path: a new table restarts from zero.
  logic [CountBits-1:0] base_cnt;
  logic [SumBits-1:0]   base_tot, new_tot;
  logic                 base_ovf, table_full, wr_en;

  assign base_cnt   = (head_op == OpLoadFirst) ? '0 : count_q;
  assign base_tot   = (head_op == OpLoadFirst) ? '0 : total_q;
  assign base_ovf   = (head_op == OpLoadFirst) ? 1'b0 : ovf_q;
  assign table_full = (base_cnt == CountBits'(Depth));
  assign new_tot    = base_tot + SumBits'(head_data[WeightBits-1:0]);

  assign pop_o = (state_q == StIdle) && head_valid_i;
  assign wr_en = pop_o && is_load && !table_full;

  // r * total in two halves through one shared multiplier.
  logic [HiBits-1:0]          mul_b;
  logic [FracBits+HiBits-1:0] mul_p;

  assign mul_b = (state_q == StMulLo) ? HiBits'(total_q[LoBits-1:0]) : total_q[SumBits-1:LoBits];
  assign mul_p = r_q * mul_b;

  // One search step per cycle against the registered table read.
  logic [CmpBits-1:0] lhs;
  logic               meets;
  logic [IdxBits-1:0] lo_n, hi_n, mid_n, rd_addr;

  assign lhs   = CmpBits'(rd_data_q) << FracBits;
  assign meets = (lhs >= prod_q);
  assign lo_n  = meets ? lo_q : mid_q + IdxBits'(1);
  assign hi_n  = meets ? mid_q : hi_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

  assign rd_addr = (state_q == StSearch) ? mid_n : (hi_q >> 1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prefix_mem[base_cnt[IdxBits-1:0]] <= new_tot;
    end
    rd_data_q <= prefix_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      r_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      prod_q      <= '0;
      res_valid_q <= 1'b0;
      index_q     <= '0;
      res_ovf_q   <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (head_valid_i && is_load) begin
            if (table_full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= base_cnt + CountBits'(1);
              total_q <= new_tot;
              ovf_q   <= base_ovf;
            end
          end else if (head_valid_i && is_query) begin
            r_q <= head_data[FracBits-1:0];
            // Empty, single-entry or zero-weight table: answer is entry 0.
            if (count_q <= CountBits'(1) || total_q == '0) begin
              res_valid_q <= 1'b1;
              index_q     <= '0;
              res_ovf_q   <= ovf_q;
            end else begin
              lo_q    <= '0;
              hi_q    <= IdxBits'(count_q - CountBits'(1));
              state_q <= StMulLo;
            end
          end
        end
        StMulLo: begin
          prod_q  <= CmpBits'(mul_p);
          state_q <= StMulHi;
        end
        StMulHi: begin
          prod_q  <= prod_q + (CmpBits'(mul_p) << LoBits);
          mid_q   <= hi_q >> 1;
          state_q <= StSearch;
        end
        StSearch: begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          mid_q <= mid_n;
          if (lo_n == hi_n) begin
            res_valid_q <= 1'b1;
            index_q     <= IndexBits'(lo_n);
            res_ovf_q   <= ovf_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o  = res_valid_q;
  assign index_o         = index_q;
  assign overflow_seen_o = res_ovf_q;

endmodule

`default_nettype wire

>>> src/discrete_cdf_sampler.sv
// Discrete CDF sampler: start/busy command port, front end, queue, back end.
// Depends on dcs_pkg, dcs_front, dcs_fifo and dcs_back.
//
// Picks an index from a discrete distribution by inverse-CDF lookup. A load
// word (req_type_i = 0) appends one weight and stores its running prefix sum;
// first_entry_i on a load starts a new table and clears the overflow flag.
// A query word (req_type_i = 1) returns the lowest index i with
// prefix[i] * 2^FracBits >= r_fraction_i * total, computed exactly in
// integers. An empty table or a zero total returns index 0. Loads beyond
// Depth entries are dropped and set overflow_seen_o on later results.
// A word is taken at a rising edge with start_i high and busy_o low; busy_o
// only rises when the two-word queue is full. Results appear on index_o and
// overflow_seen_o for exactly one cycle, marked by result_valid_o: the
// receiver cannot stall, so it must take each result in that cycle. Loads
// give no result.
//
// Flow: a word waits in the queue until the back end is idle and pops it. A
// load is then executed as it is popped. A query on a table of n > 1 entries
// with a non-zero total is popped, forms r * total in two halves (StMulLo,
// StMulHi) on a shared half-width multiplier, then takes one binary-search
// step per cycle, each bound by a registered read of the prefix-sum memory
// and a compare. Trivial queries are answered at the pop. Each result is
// registered and appears in the cycle after the search ends. The table needs
// no clearing after reset: only entries below the fill count feed a result.
`timescale 1ns / 1ps
`default_nettype none

module discrete_cdf_sampler import dcs_pkg::*; #(
  parameter int Depth      = DefDepth,
  parameter int WeightBits = DefWeightBits,
  parameter int FracBits   = DefFracBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  req_type_i,
  input  wire logic                  first_entry_i,
  input  wire logic [WeightBits-1:0] weight_i,
  input  wire logic [FracBits-1:0]   r_fraction_i,
  output logic                       result_valid_o,
  output logic [IndexBits-1:0]       index_o,
  output logic                       overflow_seen_o
);

  // Queue word: command class on top, weight or fraction below.
  localparam int DataBits = (WeightBits > FracBits) ? WeightBits : FracBits;
  localparam int WordBits = DataBits + OpBits;

  logic                push, full, head_valid, pop;
  logic [WordBits-1:0] push_word, head_word;

  dcs_front #(
    .WeightBits(WeightBits),
    .FracBits  (FracBits)
  ) u_front (
    .start_i      (start_i),
    .req_type_i   (req_type_i),
    .first_entry_i(first_entry_i),
    .weight_i     (weight_i),
    .r_fraction_i (r_fraction_i),
    .full_i       (full),
    .busy_o       (busy_o),
    .push_o       (push),
    .word_o       (push_word)
  );

  dcs_fifo #(
    .Width(WordBits),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_word),
    .full_o (full),
    .valid_o(head_valid),
    .data_o (head_word),
    .pop_i  (pop)
  );

  // Back end pops a word only when idle; the search holds the queue head off.
  dcs_back #(
    .Depth     (Depth),
    .WeightBits(WeightBits),
    .FracBits  (FracBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_word_i    (head_word),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .index_o        (index_o),
    .overflow_seen_o(overflow_seen_o)
  );

endmodule

`default_nettype wire

>>> src/dcs_checker.sv
// Port-level checks of the discrete CDF sampler, bound to the top level.
// Depends on dcs_pkg and discrete_cdf_sampler_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "discrete_cdf_sampler_defines.svh"

module dcs_checker import dcs_pkg::*; #(
  parameter int Depth = DefDepth
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start_i,
  input wire logic                 busy_o,
  input wire logic                 req_type_i,
  input wire logic                 result_valid_o,
  input wire logic [IndexBits-1:0] index_o
);

  localparam int MaxPending  = QueueDepth + 1;
  localparam int PendingBits = $clog2(MaxPending + 2);

  // Queries taken whose result has not yet been shown.
  logic [PendingBits-1:0] pending_q, pending_d;
  logic                   query_acc;

  assign query_acc = start_i && !busy_o && req_type_i;

  always_comb begin
    pending_d = pending_q + PendingBits'(query_acc) - PendingBits'(result_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `DCS_ASSERT(a_result_has_query, !result_valid_o || pending_q != '0, "result without query")
  `DCS_ASSERT(a_pending_bound, pending_q <= PendingBits'(MaxPending), "too many queries held")
  `DCS_ASSERT_NEXT(a_no_stray_result, pending_q == '0, !result_valid_o, "result from nothing")
  `DCS_ASSERT(a_index_range, !result_valid_o || int'(index_o) < Depth, "index past table")

endmodule

bind discrete_cdf_sampler dcs_checker #(.Depth(Depth)) u_dcs_checker (.*);

`default_nettype wire
